// ===== sv/dbhr_pkg.sv =====
// Types and constants shared by the button debounce, hold and repeat block.
package dbhr_pkg;

    localparam int NUM_BTN   = 4;
    localparam int BTN_IDX_W = 2;
    localparam int PRESS_W   = 11;
    localparam int HOLD_W    = 15;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [PRESS_W-1:0] PRESS_MAX = '1;
    localparam logic [HOLD_W-1:0]  HOLD_MAX  = 15'd30000;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_RELOAD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MASK      = 3'd4;

    typedef struct packed {
        logic [MASK_W-1:0]  active_high_mask;
        logic [PRESS_W-1:0] debounce_ticks;
        logic [PRESS_W-1:0] hold_ticks;
        logic [PRESS_W-1:0] repeat_reload;
        logic [MASK_W-1:0]  repeat_mask;
    } cfg_t;

    typedef struct packed {
        logic [MASK_W-1:0]    release_mask;
        logic [HOLD_W-1:0]    hold_total;
        logic [BTN_IDX_W-1:0] event_button;
        logic                 repeat_push;
        logic                 hold_fire;
        logic                 push_fire;
    } res_t;

    typedef logic [NUM_BTN-1:0][PRESS_W-1:0] press_arr_t;
    typedef logic [NUM_BTN-1:0][HOLD_W-1:0]  hold_arr_t;

endpackage

// ===== sv/dbhr_cfg.sv =====
// Configuration register file for the debounce block.
module dbhr_cfg
    import dbhr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACTIVE_HIGH_MASK: cfg_next.active_high_mask = cfg_data[MASK_W-1:0];
                CFG_DEBOUNCE_TICKS:   cfg_next.debounce_ticks   = cfg_data[PRESS_W-1:0];
                CFG_HOLD_TICKS:       cfg_next.hold_ticks       = cfg_data[PRESS_W-1:0];
                CFG_REPEAT_RELOAD:    cfg_next.repeat_reload    = cfg_data[PRESS_W-1:0];
                CFG_REPEAT_MASK:      cfg_next.repeat_mask      = cfg_data[MASK_W-1:0];
                default:              cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_high_mask <= 4'd8;
            cfg_reg.debounce_ticks   <= 11'd30;
            cfg_reg.hold_ticks       <= 11'd1500;
            cfg_reg.repeat_reload    <= 11'd1000;
            cfg_reg.repeat_mask      <= 4'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/dbhr_scan.sv =====
// Priority scan over the buttons: next counter values and the event of one tick.
module dbhr_scan
    import dbhr_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [MASK_W-1:0] levels,
    input  press_arr_t        press_cnt,
    input  hold_arr_t         hold_cnt,
    output press_arr_t        press_next,
    output hold_arr_t         hold_next,
    output res_t              res
);

    logic [NUM_BTN-1:0] pressed;

    assign pressed = ~(levels ^ cfg.active_high_mask);

    always_comb
    begin
        logic               seen;
        logic [PRESS_W-1:0] pc_inc;
        seen       = 1'b0;
        pc_inc     = '0;
        press_next = press_cnt;
        hold_next  = hold_cnt;
        res        = '0;
        for (int i = 0; i < NUM_BTN; i++)
        begin
            // buttons after the first pressed one stay frozen
            if (!seen)
            begin
                if (pressed[i])
                begin
                    seen             = 1'b1;
                    res.event_button = BTN_IDX_W'(i);
                    if (press_cnt[i] != PRESS_MAX)
                    begin
                        pc_inc        = press_cnt[i] + 1'b1;
                        press_next[i] = pc_inc;
                        if (pc_inc == cfg.debounce_ticks)
                        begin
                            res.push_fire = 1'b1;
                        end
                        else if (pc_inc == cfg.hold_ticks)
                        begin
                            res.hold_fire   = 1'b1;
                            res.hold_total  = hold_cnt[i];
                            res.repeat_push = cfg.repeat_mask[i]
                                              && (hold_cnt[i] != HOLD_W'(0))
                                              && (hold_cnt[i] != HOLD_W'(2));
                            hold_next[i]    = (hold_cnt[i] < HOLD_MAX)
                                              ? hold_cnt[i] + 1'b1 : HOLD_MAX;
                            press_next[i]   = cfg.repeat_reload;
                        end
                    end
                end
                else
                begin
                    res.release_mask[i] = (press_cnt[i] > cfg.debounce_ticks);
                    press_next[i]       = '0;
                    hold_next[i]        = '0;
                end
            end
        end
    end

endmodule

// ===== sv/button_debounce_hold_repeat_core.sv =====
// Top level: debounce, hold detection and auto-repeat for four push buttons.
//
// Usage
//   s_axis: one beat per timer tick; tdata[3:0] carries the raw pin level of
//           each button (bit i is button i).
//   m_axis: exactly one result beat per input beat, in order.
//   cfg:    register writes (index, data); always ready. Write only while
//           the block holds no beat in flight.
// Timing
//   A taken beat lands in the input register; once the result register can
//   advance, the buttons are scanned, the press and hold counters update and
//   the result register loads; the result is offered from that register.
//   One beat per cycle is sustained while m_axis_tready stays high: the single
//   scan pass between the two registers sets that figure.
// Reset
//   Counters clear, both registers go empty, configuration takes its
//   defaults (active-high mask 8, debounce 30, hold 1500, reload 1000,
//   repeat mask 3).
// Stall
//   While m_axis_tready is low the result holds and one further beat waits
//   in the input register; s_axis_tready then drops.
module button_debounce_hold_repeat_core
    import dbhr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [3:0] button_levels, [7:4] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] push_fire, [1] hold_fire, [2] repeat_push, [4:3] event_button,
    // [19:5] hold_total, [23:20] release_mask
    output logic [23:0]           m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [MASK_W-1:0] levels_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              res_reg;
    res_t              res_next;
    press_arr_t        press_cnt_reg;
    press_arr_t        press_cnt_next;
    hold_arr_t         hold_cnt_reg;
    hold_arr_t         hold_cnt_next;
    logic              advance;
    logic              proc;

    dbhr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dbhr_scan u_scan (
        .cfg        (cfg),
        .levels     (levels_reg),
        .press_cnt  (press_cnt_reg),
        .hold_cnt   (hold_cnt_reg),
        .press_next (press_cnt_next),
        .hold_next  (hold_cnt_next),
        .res        (res_next)
    );

    // advance the result register when it is empty or being taken
    assign advance        = !out_valid_reg || m_axis_tready;
    assign proc           = in_valid_reg && advance;
    assign s_axis_tready  = !in_valid_reg || advance;
    assign in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            press_cnt_reg <= '0;
            hold_cnt_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc)
            begin
                press_cnt_reg <= press_cnt_next;
                hold_cnt_reg  <= hold_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            levels_reg <= s_axis_tdata[MASK_W-1:0];
        end
        if (proc)
        begin
            res_reg <= res_next;
        end
    end

    logic hold_over;

    always_comb
    begin
        hold_over = 1'b0;
        for (int i = 0; i < NUM_BTN; i++)
        begin
            hold_over = hold_over || (hold_cnt_reg[i] > HOLD_MAX);
        end
    end

    a_push_hold_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.push_fire && res_reg.hold_fire))
        else $error("push and hold fired on the same tick");

    a_repeat_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.repeat_push) |-> res_reg.hold_fire)
        else $error("repeat push without hold event");

    a_hold_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.hold_fire) |-> (res_reg.hold_total == '0))
        else $error("hold total reported without hold event");

    a_hold_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_over)
        else $error("hold counter above its ceiling");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> ($stable(press_cnt_reg) && $stable(hold_cnt_reg)))
        else $error("counters changed without a processed beat");

endmodule

// ===== tb/sv/button_debounce_hold_repeat_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the four-button debounce, hold and auto-repeat core.
module button_debounce_hold_repeat_core_tb;
    import dbhr_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int MAX_IDLE       = 14;
    localparam int RANDOM_TICKS   = 1400;
    localparam int PHASES         = 12;
    localparam int MAX_RUN        = 40;
    localparam int LONG_HOLD_OFF  = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    localparam cfg_t CFG_AFTER_RESET = '{4'd8, 11'd30, 11'd1500, 11'd1000, 4'd3};
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_REPEAT_MASK + 3'd1;
    localparam res_t NO_EVENT = '0;

    typedef enum logic { ROW_BEAT, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [3:0]             levels;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        bit                     typed;
        res_t                   want;
    } script_row_t;

    localparam int SCRIPT_LEN = 33;

    // Defaults first, then a short repeat sequence, the counter at its top,
    // and debounce equal to hold.
    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_BEAT,  4'b0111, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b1, NO_EVENT},
        '{ROW_BEAT,  4'b1111, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b1,
          '{4'd0, 15'd0, 2'd3, 1'b0, 1'b0, 1'b0}},
        '{ROW_BEAT,  4'b0000, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b1,
          '{4'd0, 15'd0, 2'd0, 1'b0, 1'b0, 1'b0}},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b1,
          '{4'd0, 15'd0, 2'd1, 1'b0, 1'b0, 1'b0}},
        '{ROW_WRITE, 4'b0000, CFG_ACTIVE_HIGH_MASK, 11'h00F, 1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_DEBOUNCE_TICKS,   11'd2,   1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_HOLD_TICKS,       11'd4,   1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_REPEAT_RELOAD,    11'd3,   1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_REPEAT_MASK,      11'h00F, 1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_UNUSED,           11'h7FF, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0001, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b1110, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_ACTIVE_HIGH_MASK, 11'd0,   1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_DEBOUNCE_TICKS,   11'h7FF, 1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_HOLD_TICKS,       11'd1,   1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_REPEAT_RELOAD,    11'h7FF, 1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_REPEAT_MASK,      11'd0,   1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b1110, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b1110, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b1110, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b1111, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_DEBOUNCE_TICKS,   11'd1,   1'b0, NO_EVENT},
        '{ROW_WRITE, 4'b0000, CFG_HOLD_TICKS,       11'd1,   1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0111, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b0111, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT},
        '{ROW_BEAT,  4'b1111, CFG_ACTIVE_HIGH_MASK, 11'd0, 1'b0, NO_EVENT}
    };

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [3:0] button_levels, [7:4] zero
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] push_fire, [1] hold_fire, [2] repeat_push, [4:3] event_button,
    // [19:5] hold_total, [23:20] release_mask
    logic [23:0]           m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Shadow of the block: settings and per-button counters
    cfg_t               shadow_cfg = CFG_AFTER_RESET;
    logic [PRESS_W-1:0] press_cnt [NUM_BTN];
    logic [HOLD_W-1:0]  hold_cnt  [NUM_BTN];
    res_t               pending_results [$];

    int errors        = 0;
    int ticks_sent    = 0;
    int pushes_seen   = 0;
    int holds_seen    = 0;
    int repeats_seen  = 0;
    int releases_seen = 0;
    bit snd_burst     = 1'b0;
    bit rcv_burst     = 1'b0;
    bit hold_off_req  = 1'b0;

    button_debounce_hold_repeat_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int draw_idle(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Scan one tick: released buttons before the first pressed one clear, the first pressed one counts.
    function automatic res_t scan_buttons(input logic [3:0] levels);
        res_t              r;
        logic [HOLD_W-1:0] h;
        bit                found;
        r     = '0;
        found = 1'b0;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            if (!found)
            begin
                if (levels[b] == shadow_cfg.active_high_mask[b])
                begin
                    found          = 1'b1;
                    r.event_button = BTN_IDX_W'(b);
                    if (press_cnt[b] != PRESS_MAX)
                    begin
                        press_cnt[b] = press_cnt[b] + 1'b1;
                        if (press_cnt[b] == shadow_cfg.debounce_ticks)
                            r.push_fire = 1'b1;
                        else if (press_cnt[b] == shadow_cfg.hold_ticks)
                        begin
                            h             = hold_cnt[b];
                            r.hold_fire   = 1'b1;
                            r.hold_total  = h;
                            r.repeat_push = shadow_cfg.repeat_mask[b] && h != 0 && h != 2;
                            if (h < HOLD_MAX)
                                h = h + 1'b1;
                            hold_cnt[b]  = h;
                            press_cnt[b] = shadow_cfg.repeat_reload;
                        end
                    end
                end
                else
                begin
                    if (press_cnt[b] > shadow_cfg.debounce_ticks)
                        r.release_mask[b] = 1'b1;
                    press_cnt[b] = '0;
                    hold_cnt[b]  = '0;
                end
            end
        end
        return r;
    endfunction

    task automatic offer_levels(input logic [3:0] levels, input bit typed = 1'b0,
                                input res_t want = '0);
        int   gap;
        res_t predicted;
        gap = draw_idle(snd_burst);
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, levels};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = scan_buttons(levels);
        pending_results.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ACTIVE_HIGH_MASK: shadow_cfg.active_high_mask = val[MASK_W-1:0];
            CFG_DEBOUNCE_TICKS:   shadow_cfg.debounce_ticks   = val;
            CFG_HOLD_TICKS:       shadow_cfg.hold_ticks       = val;
            CFG_REPEAT_RELOAD:    shadow_cfg.repeat_reload    = val;
            CFG_REPEAT_MASK:      shadow_cfg.repeat_mask      = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly small tick counts so that holds and repeats come often
    function automatic logic [CFG_DATA_W-1:0] pick_ticks(input int lo, input int small_hi);
        case ($urandom_range(0, 7))
            0:       return CFG_DATA_W'(lo);
            1:       return '1;
            default: return CFG_DATA_W'($urandom_range(lo, small_hi));
        endcase
    endfunction

    task automatic match_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (pending_results.size() == 0)
        begin
            $error("result beat %h with no tick outstanding", got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        match_field("push_fire",    want.push_fire,    got.push_fire);
        match_field("hold_fire",    want.hold_fire,    got.hold_fire);
        match_field("repeat_push",  want.repeat_push,  got.repeat_push);
        match_field("event_button", want.event_button, got.event_button);
        match_field("hold_total",   want.hold_total,   got.hold_total);
        match_field("release_mask", want.release_mask, got.release_mask);
        pushes_seen   += got.push_fire;
        holds_seen    += got.hold_fire;
        repeats_seen  += got.repeat_push;
        releases_seen += (got.release_mask != 0);
    endtask

    // Result side: check each beat, then stall for a drawn number of cycles or, on request, for the long hold-off
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result(res_t'(m_axis_tdata));
                if (hold_off_req)
                begin
                    stall_left   = LONG_HOLD_OFF;
                    hold_off_req = 1'b0;
                end
                else
                    stall_left = draw_idle(rcv_burst);
                if (stall_left > 0)
                    m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("button_debounce_hold_repeat_core_tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int                    phase_end;
        int                    tgt;
        int                    directed_ticks;
        logic [3:0]            low_bits;
        logic [3:0]            pressed;
        logic [3:0]            act;
        logic [3:0]            rpm;
        logic [CFG_DATA_W-1:0] deb;
        logic [CFG_DATA_W-1:0] hld;
        logic [CFG_DATA_W-1:0] rld;

        for (int b = 0; b < NUM_BTN; b++)
        begin
            press_cnt[b] = '0;
            hold_cnt[b]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
                write_reg(script[i].idx, script[i].val);
            else
                offer_levels(script[i].levels, script[i].typed, script[i].want);
        end
        directed_ticks = ticks_sent;

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                act = 4'h0; deb = 11'd1;   hld = 11'h7FF; rld = 11'd0; rpm = 4'h0;
            end
            else if (p == 1)
            begin
                act = 4'hF; deb = 11'h7FF; hld = 11'd2;   rld = 11'd0; rpm = 4'hF;
            end
            else
            begin
                act = 4'($urandom);
                rpm = 4'($urandom);
                deb = pick_ticks(1, 8);
                hld = pick_ticks(1, 12);
                rld = pick_ticks(0, 12);
            end
            write_reg(CFG_ACTIVE_HIGH_MASK, CFG_DATA_W'(act));
            write_reg(CFG_DEBOUNCE_TICKS, deb);
            write_reg(CFG_HOLD_TICKS, hld);
            write_reg(CFG_REPEAT_RELOAD, rld);
            write_reg(CFG_REPEAT_MASK, CFG_DATA_W'(rpm));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_UNUSED + CFG_IDX_W'($urandom_range(0, 2)),
                          CFG_DATA_W'($urandom));

            snd_burst = (p == 2) || ($urandom_range(0, 3) == 0);
            rcv_burst = ($urandom_range(0, 3) == 0);
            // Hold the result side off while ticks keep coming
            hold_off_req = (p == 2);

            phase_end = directed_ticks + (p + 1) * (RANDOM_TICKS / PHASES);
            while (ticks_sent < phase_end)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    // Press one button for a run, with the lower ones released, and now and then a random pattern
                    tgt      = $urandom_range(0, NUM_BTN - 1);
                    low_bits = 4'((1 << (tgt + 1)) - 1);
                    repeat ($urandom_range(1, MAX_RUN))
                    begin
                        pressed = (4'($urandom) & ~low_bits) | 4'(1 << tgt);
                        if ($urandom_range(0, 19) == 0)
                            pressed = 4'($urandom);
                        offer_levels(~(pressed ^ shadow_cfg.active_high_mask));
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        pressed = ($urandom_range(0, 1) == 0) ? 4'b0000
                                  : 4'($urandom) & ~4'(1 << tgt);
                        offer_levels(~(pressed ^ shadow_cfg.active_high_mask));
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 5))
                        offer_levels(4'($urandom));
                end
            end
        end

        drain_results();
        cfg_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d ticks (%0d directed) over %0d settings phases, errors %0d",
                 ticks_sent, directed_ticks, PHASES, errors);
        $display("Events: %0d pushes, %0d holds, %0d repeat pushes, %0d release beats",
                 pushes_seen, holds_seen, repeats_seen, releases_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("button_debounce_hold_repeat_core_tb OK");
        else
            $display("button_debounce_hold_repeat_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dbhr_pkg.sv
sv/dbhr_cfg.sv
sv/dbhr_scan.sv
sv/button_debounce_hold_repeat_core.sv
tb/sv/button_debounce_hold_repeat_core_tb.sv
